// ===== design/dbq_pkg.sv =====
`default_nettype none

package dbq_pkg;

    // Defaults for the top-level parameters.
    localparam int LEVELS_DEF = 16;
    localparam int ACTORS_DEF = 64;

    // Fixed field widths.
    localparam int ID_W    = 6;
    localparam int DEPTH_W = 16;

    // Command codes carried in s_tuser.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_WALK,
        ST_FLUSH
    } dbq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_insert;   // capture an insert request, read the level tail
        logic start_drain;  // begin a drain at the deepest level
        logic commit;       // perform the insert writes
        logic scan_read;    // read head and tail of the current level
        logic lvl_dec;      // step to the next shallower level
        logic take;         // take the current id of the walk
        logic flush;        // emit the final result and clear the queue
    } dbq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lvl_nonempty; // current level holds ids
        logic lvl_zero;     // current level is the shallowest one
        logic at_tail;      // current id is the tail of its level
        logic pend_valid;   // an id waits in the pending register
        logic out_free;     // output register can take a result this cycle
    } dbq_status_t;

endpackage

`default_nettype wire

// ===== design/dbq_ctrl.sv =====
`default_nettype none

module dbq_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                req_valid,
    input  wire logic                req_command,
    output logic                     req_ready,
    input  wire dbq_pkg::dbq_status_t status,
    output dbq_pkg::dbq_cmd_t         cmd
);
    import dbq_pkg::*;

    dbq_state_t state_reg;
    dbq_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    if (req_command == CMD_DRAIN) begin
                        cmd.start_drain = 1'b1;
                        state_next      = ST_SCAN;
                    end else begin
                        cmd.cap_insert = 1'b1;
                        state_next     = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (status.lvl_nonempty) begin
                    cmd.scan_read = 1'b1;
                    state_next    = ST_WALK;
                end else if (status.lvl_zero) begin
                    state_next = ST_FLUSH;
                end else begin
                    cmd.lvl_dec = 1'b1;
                end
            end
            ST_WALK: begin
                // A pending id can only be replaced once it has somewhere to go.
                if (!status.pend_valid || status.out_free) begin
                    cmd.take = 1'b1;
                    if (status.at_tail) begin
                        if (status.lvl_zero) begin
                            state_next = ST_FLUSH;
                        end else begin
                            cmd.lvl_dec = 1'b1;
                            state_next  = ST_SCAN;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/dbq_datapath.sv =====
`default_nettype none

module dbq_datapath #(
    parameter int LEVELS = dbq_pkg::LEVELS_DEF,
    parameter int ACTORS = dbq_pkg::ACTORS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [dbq_pkg::DEPTH_W-1:0] in_depth,
    input  wire logic [dbq_pkg::ID_W-1:0]    in_actor_id,
    input  wire dbq_pkg::dbq_cmd_t           cmd,
    output dbq_pkg::dbq_status_t             status,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [dbq_pkg::ID_W-1:0]         out_actor,
    output logic                             out_last,
    output logic                             out_empty
);
    import dbq_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW = (ACTORS > 1) ? $clog2(ACTORS) : 1;
    localparam logic signed [DEPTH_W-1:0] MAX_LEVEL = DEPTH_W'(LEVELS - 1);

    // Level and link storage.
    logic [AW-1:0] head_mem [LEVELS];
    logic [AW-1:0] tail_mem [LEVELS];
    logic [AW-1:0] link_mem [ACTORS];

    logic [AW-1:0] head_rd_reg;
    logic [AW-1:0] tail_rd_reg;
    logic [AW-1:0] link_rd_reg;

    logic [LEVELS-1:0] nonempty_reg;
    logic [ACTORS-1:0] queued_reg;

    logic [LW-1:0]   lvl_reg;
    logic [ID_W-1:0] id_reg;
    logic            first_reg;
    logic            pend_valid_reg;
    logic [AW-1:0]   pend_id_reg;

    logic            out_valid_reg;
    logic [ID_W-1:0] out_actor_reg;
    logic            out_last_reg;
    logic            out_empty_reg;

    logic [LW-1:0] clamp_lvl;
    logic [LW-1:0] tail_addr;
    logic [AW-1:0] cur_id;
    logic          ins_ok;
    logic          out_free;
    logic          out_load;

    // Clamp the signed depth into the level range.
    always_comb begin
        if (in_depth[DEPTH_W-1]) begin
            clamp_lvl = '0;
        end else if ($signed(in_depth) > MAX_LEVEL) begin
            clamp_lvl = LW'(LEVELS - 1);
        end else begin
            clamp_lvl = in_depth[LW-1:0];
        end
    end

    // The id compare is one bit wider so that a full 64-entry actor range still fits.
    assign tail_addr = cmd.scan_read ? lvl_reg : clamp_lvl;
    assign cur_id    = first_reg ? head_rd_reg : link_rd_reg;
    assign ins_ok    = ({1'b0, id_reg} < (ID_W + 1)'(ACTORS)) && !queued_reg[id_reg[AW-1:0]];
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (cmd.take && pend_valid_reg) || cmd.flush;

    // Head and tail memories: one write and one registered read each.
    always_ff @(posedge aclk) begin
        if (cmd.commit && ins_ok) begin
            tail_mem[lvl_reg] <= id_reg[AW-1:0];
            if (!nonempty_reg[lvl_reg]) begin
                head_mem[lvl_reg] <= id_reg[AW-1:0];
            end
        end
        if (cmd.cap_insert || cmd.scan_read) begin
            tail_rd_reg <= tail_mem[tail_addr];
        end
        if (cmd.scan_read) begin
            head_rd_reg <= head_mem[lvl_reg];
        end
    end

    // Link memory: the old tail points to the new id; the walk follows links.
    always_ff @(posedge aclk) begin
        if (cmd.commit && ins_ok && nonempty_reg[lvl_reg]) begin
            link_mem[tail_rd_reg] <= id_reg[AW-1:0];
        end
        if (cmd.take && (cur_id != tail_rd_reg)) begin
            link_rd_reg <= link_mem[cur_id];
        end
    end

    // Request capture and walk position.
    always_ff @(posedge aclk) begin
        if (cmd.cap_insert) begin
            lvl_reg <= clamp_lvl;
            id_reg  <= in_actor_id;
        end else if (cmd.start_drain) begin
            lvl_reg <= LW'(LEVELS - 1);
        end else if (cmd.lvl_dec) begin
            lvl_reg <= lvl_reg - LW'(1);
        end
        if (cmd.scan_read) begin
            first_reg <= 1'b1;
        end else if (cmd.take) begin
            first_reg <= 1'b0;
        end
        if (cmd.take) begin
            pend_id_reg <= cur_id;
        end
    end

    // Occupancy flags and the pending flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg   <= '0;
            queued_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit && ins_ok) begin
                nonempty_reg[lvl_reg]           <= 1'b1;
                queued_reg[id_reg[AW-1:0]]      <= 1'b1;
            end
            if (cmd.flush) begin
                nonempty_reg <= '0;
                queued_reg   <= '0;
            end
            if (cmd.start_drain) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.take) begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    // Output register: a pending id leaves once the next one is known.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (pend_valid_reg) begin
                out_actor_reg <= ID_W'(pend_id_reg);
                out_empty_reg <= 1'b0;
            end else begin
                out_actor_reg <= '0;
                out_empty_reg <= 1'b1;
            end
            out_last_reg <= cmd.flush;
        end
    end

    assign status.lvl_nonempty = nonempty_reg[lvl_reg];
    assign status.lvl_zero     = (lvl_reg == '0);
    assign status.at_tail      = (cur_id == tail_rd_reg);
    assign status.pend_valid   = pend_valid_reg;
    assign status.out_free     = out_free;

    assign out_valid = out_valid_reg;
    assign out_actor = out_actor_reg;
    assign out_last  = out_last_reg;
    assign out_empty = out_empty_reg;

endmodule

`default_nettype wire

// ===== design/depth_bucket_draw_queue.sv =====
// Insert: accepted in ST_IDLE and written in the next cycle; no new request is taken meanwhile.
// Drain: one level is scanned per cycle from the deepest down, and the link memory read paces
// the walk at one id per cycle while the output register can take the pending id.
// Each id waits in a pending register until the next id is taken or the flush step runs,
// and is presented on the output the cycle after that.
// Reset (aresetn low at a clock edge) empties every level; head, tail and link memories
// are not cleared and need no clearing pass.
`default_nettype none

module depth_bucket_draw_queue #(
    parameter int LEVELS = dbq_pkg::LEVELS_DEF,
    parameter int ACTORS = dbq_pkg::ACTORS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [15:0] depth (signed), [21:16] actor_id, [23:22] zero
    input  wire logic [0:0]  s_tuser,   // [0] command: 0 insert, 1 drain
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [5:0] actor_out, [7:6] zero
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // [0] empty_res
);
    import dbq_pkg::*;

    dbq_cmd_t        cmd;
    dbq_status_t     status;
    logic [ID_W-1:0] out_actor;
    logic            out_empty;

    // Sequencing of insert and drain requests.
    dbq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_command (s_tuser[0]),
        .req_ready   (s_tready),
        .status      (status),
        .cmd         (cmd)
    );

    // Level lists, flags and the output register.
    dbq_datapath #(
        .LEVELS (LEVELS),
        .ACTORS (ACTORS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_depth    (s_tdata[DEPTH_W-1:0]),
        .in_actor_id (s_tdata[DEPTH_W+ID_W-1:DEPTH_W]),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_actor   (out_actor),
        .out_last    (m_tlast),
        .out_empty   (out_empty)
    );

    assign m_tdata = 8'(out_actor);
    assign m_tuser = out_empty;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dbq_pkg::*;

    localparam int LEVELS      = LEVELS_DEF;
    localparam int ACTORS      = ACTORS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = LEVELS + 16;

    // One draw result as it leaves the block.
    typedef struct packed {
        logic [ID_W-1:0] actor;
        logic            last;
        logic            empty;
    } draw_slot_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [15:0] depth (signed), [21:16] actor_id, [23:22] zero
    logic [0:0]  s_tuser  = '0;   // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [5:0] actor_out, [7:6] zero
    logic        m_tlast;
    logic [0:0]  m_tuser;         // [0] empty_res

    // Shadow copy of the bucket lists.
    logic [ID_W-1:0] lvl_head [LEVELS];
    logic [ID_W-1:0] lvl_tail [LEVELS];
    logic            lvl_busy [LEVELS];
    logic [ID_W-1:0] link_mem [ACTORS];
    logic            actor_held [ACTORS];

    draw_slot_t draw_order_q[$];

    int  mismatch_count  = 0;
    int  cycle_count     = 0;
    int  src_idle_pct    = 0;
    int  sink_idle_pct   = 0;
    int  hold_requests   = 0;
    int  hold_len        = 0;

    depth_bucket_draw_queue #(
        .LEVELS(LEVELS),
        .ACTORS(ACTORS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Apply one accepted request to the shadow lists and queue up the draw order it causes.
    task automatic predict_request(input logic cmd, input logic [DEPTH_W-1:0] depth,
                                   input logic [ID_W-1:0] id);
        logic signed [DEPTH_W-1:0] d;
        logic [ID_W-1:0]           walk_id;
        logic [ID_W-1:0]           walk[$];
        int                        lvl;
        int                        k;
        if (cmd == CMD_INSERT) begin
            d = depth;
            if (d < 0)
                lvl = 0;
            else if (d > LEVELS - 1)
                lvl = LEVELS - 1;
            else
                lvl = int'(d);
            if (!actor_held[id]) begin
                if (!lvl_busy[lvl]) begin
                    lvl_head[lvl] = id;
                    lvl_busy[lvl] = 1'b1;
                end else begin
                    link_mem[lvl_tail[lvl]] = id;
                end
                lvl_tail[lvl]  = id;
                actor_held[id] = 1'b1;
            end
        end else begin
            // Deepest level first, FIFO order inside a level.
            for (lvl = LEVELS - 1; lvl >= 0; lvl--) begin
                if (lvl_busy[lvl]) begin
                    walk_id = lvl_head[lvl];
                    k = 0;
                    while (k < ACTORS) begin
                        walk.push_back(walk_id);
                        k++;
                        if (walk_id == lvl_tail[lvl])
                            break;
                        walk_id = link_mem[walk_id];
                    end
                end
                lvl_busy[lvl] = 1'b0;
            end
            for (k = 0; k < ACTORS; k++)
                actor_held[k] = 1'b0;
            if (walk.size() == 0) begin
                draw_order_q.push_back('{actor: '0, last: 1'b1, empty: 1'b1});
            end else begin
                for (k = 0; k < walk.size(); k++)
                    draw_order_q.push_back('{actor: walk[k], last: (k == walk.size() - 1),
                                             empty: 1'b0});
            end
        end
    endtask

    // Offer one request, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_request(input logic cmd, input logic [DEPTH_W-1:0] depth,
                                input logic [ID_W-1:0] id);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, id, depth};
        s_tuser  <= cmd;
        do
            @(posedge aclk);
        while (!s_tready);
        predict_request(cmd, depth, id);
    endtask

    // Stop offering until every queued draw result has come out.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (draw_order_q.size() != 0)
            @(posedge aclk);
    endtask

    // Mostly depths near the level range, sometimes anything a 16-bit field can hold.
    function automatic logic [DEPTH_W-1:0] random_depth();
        int v;
        case ($urandom_range(3))
            0:       v = $urandom_range(16'hFFFF);
            1:       v = $urandom_range(LEVELS - 1);
            default: v = $urandom_range(LEVELS + 5) - 3;
        endcase
        return v[DEPTH_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input draw_slot_t want,
                                   input draw_slot_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected actor=%0d last=%0d empty=%0d, got actor=%0d last=%0d empty=%0d",
                     what, want.actor, want.last, want.empty, got.actor, got.last, got.empty);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever the test asks for one.
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge aclk) begin : check_results
        draw_slot_t got;
        draw_slot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{actor: m_tdata[ID_W-1:0], last: m_tlast, empty: m_tuser[0]};
            if (draw_order_q.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = draw_order_q.pop_front();
                if (got.actor !== want.actor || got.last !== want.last ||
                    got.empty !== want.empty)
                    report_mismatch("wrong result", want, got);
            end
        end
    end

    // Extreme depths, shared levels, duplicates and empty drains.
    task automatic test_directed();
        src_idle_pct  = 37;
        sink_idle_pct = 66;
        send_request(CMD_DRAIN,  16'h0000, 6'd0);
        send_request(CMD_INSERT, 16'h8000, 6'd0);
        send_request(CMD_INSERT, 16'h7FFF, 6'd63);
        send_request(CMD_INSERT, 16'd16,   6'd5);
        send_request(CMD_INSERT, 16'hFFFF, 6'd6);
        send_request(CMD_INSERT, 16'd0,    6'd7);
        send_request(CMD_INSERT, 16'd15,   6'd8);
        send_request(CMD_INSERT, 16'd7,    6'd9);
        send_request(CMD_INSERT, 16'd7,    6'd10);
        send_request(CMD_INSERT, 16'd7,    6'd11);
        // An actor already queued must not move or repeat.
        send_request(CMD_INSERT, 16'd3,    6'd63);
        send_request(CMD_INSERT, 16'd7,    6'd9);
        send_request(CMD_INSERT, 16'd1,    6'd1);
        send_request(CMD_DRAIN,  16'hFFFF, 6'd63);
        send_request(CMD_DRAIN,  16'h5555, 6'd42);
        send_request(CMD_INSERT, 16'd14,   6'd21);
        send_request(CMD_DRAIN,  16'h0000, 6'd0);
        send_request(CMD_INSERT, 16'h8001, 6'd63);
        send_request(CMD_INSERT, 16'h7FFE, 6'd0);
        send_request(CMD_DRAIN,  16'h0000, 6'd0);
    endtask

    // Bursts of inserts closed by a drain, with stray drains and duplicate-heavy bursts.
    task automatic test_random_stream(input int target, input int src_pct, input int sink_pct);
        int              done_items;
        int              burst;
        int              k;
        int              base;
        int              stride;
        int              pool;
        bit              distinct;
        logic [ID_W-1:0] id;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        done_items    = 0;
        while (done_items < target) begin
            case ($urandom_range(9))
                0:       burst = 0;
                1:       burst = ACTORS;
                2, 3:    burst = $urandom_range(20, ACTORS - 1);
                default: burst = $urandom_range(1, 12);
            endcase
            distinct = ($urandom_range(3) != 0);
            base     = $urandom_range(ACTORS - 1);
            stride   = 2 * $urandom_range(31) + 1;
            pool     = ($urandom_range(3) == 0) ? 8 : ACTORS;
            for (k = 0; k < burst; k++) begin
                if (distinct)
                    id = ID_W'((base + k * stride) % ACTORS);
                else
                    id = ID_W'($urandom_range(pool - 1));
                if ($urandom_range(39) == 0) begin
                    send_request(CMD_DRAIN, random_depth(), id);
                    done_items++;
                end
                send_request(CMD_INSERT, random_depth(), id);
                done_items++;
            end
            send_request(CMD_DRAIN, random_depth(), ID_W'($urandom_range(ACTORS - 1)));
            done_items++;
            if ($urandom_range(7) == 0)
                wait_for_results();
        end
    endtask

    // Hold the receiver off long enough that a drain fills the output and blocks new requests.
    task automatic test_output_backpressure();
        int              k;
        logic [ID_W-1:0] id;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        wait_for_results();
        hold_len = 600;
        hold_requests++;
        for (k = 0; k < 48; k++) begin
            id = ID_W'(k);
            send_request(CMD_INSERT, random_depth(), id);
        end
        send_request(CMD_DRAIN, 16'h0000, 6'd0);
        for (k = 0; k < 16; k++) begin
            id = ID_W'((k * 5) % ACTORS);
            send_request(CMD_INSERT, random_depth(), id);
        end
        send_request(CMD_DRAIN, 16'h0000, 6'd0);
        wait_for_results();
    endtask

    initial begin
        for (int i = 0; i < LEVELS; i++) begin
            lvl_head[i] = '0;
            lvl_tail[i] = '0;
            lvl_busy[i] = 1'b0;
        end
        for (int i = 0; i < ACTORS; i++) begin
            link_mem[i]   = '0;
            actor_held[i] = 1'b0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_stream(125, 37, 66);
        test_output_backpressure();
        test_random_stream(125, 66, 37);
        test_random_stream(125, 0, 0);

        // Let the last results out, then watch for anything extra.
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (draw_order_q.size() != 0)
            report_mismatch("missing result", draw_order_q[0], '0);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
